// ----- rtl/proximity_obstacle_avoidance_drive_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the obstacle avoidance drive unit
// Each check compiles to a concurrent assertion in simulation and to nothing
// when SYNTHESIS is defined. The checks sample on clk and are off under rst.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_OBSTACLE_AVOIDANCE_DRIVE_UNIT_DEFINES_SVH
`define PROXIMITY_OBSTACLE_AVOIDANCE_DRIVE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Holds at every edge
`define POAD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("poad check failed");

// Consequent in the same cycle
`define POAD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("poad check failed");

// Consequent in the next cycle
`define POAD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("poad check failed");

`else

`define POAD_ASSERT(label, prop)
`define POAD_ASSERT_IMP(label, ante, cons)
`define POAD_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- rtl/poad_pkg.sv -----
// ----------------------------------------------------------------------------
// poad_pkg
// Types, constants and helper functions of the obstacle avoidance drive.
// ----------------------------------------------------------------------------
package poad_pkg;

  localparam int SampleBits = 12;
  localparam int NumSens    = 8;
  localparam int HalfSens   = NumSens / 2;
  localparam int NumPairs   = 3;
  localparam int IdxW       = $clog2(NumSens);
  localparam int WeightW    = 16;
  localparam int SpeedW     = 11;

  // Stream and register port widths
  localparam int InW   = ((NumSens * SampleBits + 7) / 8) * 8;
  localparam int OutW  = ((2 * SpeedW + 2 + 7) / 8) * 8;
  localparam int AddrW = IdxW + 2;
  localparam int DataW = 32;

  // Thresholds and speeds
  localparam int AvoidTh    = 2100;
  localparam int FollowTh   = 1300;
  localparam int ExitTh     = 70;
  localparam int BraitDiv   = 350;
  localparam int PeakShift  = 13;
  localparam int SpeedMax   = 800;
  localparam int LeftOfs    = 66;
  localparam int RightOfs   = 72;
  localparam int BaseSpeed  = 200;
  localparam int MirrorAdd  = 512;
  localparam int FastSpeed  = 150;
  localparam int MidSpeed   = 140;
  localparam int SlowSpeed  = 100;

  // Datapath widths
  localparam int CoefW      = WeightW + 1;
  localparam int ProdW      = CoefW + SampleBits + 1;
  localparam int HiW        = ProdW - 8;
  localparam int AccW       = SampleBits + 13;
  localparam int MagW       = AccW - 1;
  localparam int RecipShift = MagW + 9;
  localparam int RecipW     = MagW + 1;
  localparam int MulW       = MagW + RecipW;
  localparam int QuoW       = MulW - RecipShift;
  localparam int SumW       = SampleBits + 7;
  localparam int BaseW      = SampleBits;
  localparam int PeakProdW  = SampleBits + 8;

  // ceil(2^RecipShift / 350): exact quotient for any magnitude below 2^MagW
  localparam longint unsigned Recip =
    ((64'd1 << RecipShift) + BraitDiv - 1) / BraitDiv;

  typedef logic [SampleBits-1:0]       sample_t;
  typedef logic signed [WeightW-1:0]   weight_t;
  typedef logic signed [CoefW-1:0]     coef_t;
  typedef logic signed [BaseW-1:0]     base_t;
  typedef logic signed [AccW-1:0]      acc_t;
  typedef logic signed [SpeedW-1:0]    speed_t;

  // One weighted reading: product divided by 256 (floor) and a flag for a
  // nonzero remainder
  typedef struct packed {
    logic signed [HiW-1:0] hi;
    logic                  frac;
  } term_t;

  // Load enables of the pipeline stages behind stage two
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic so;
  } stage_en_t;

  function automatic logic above(sample_t d, int th);
    return int'(d) > th;
  endfunction

  function automatic term_t make_term(coef_t coef, sample_t d);
    logic signed [ProdW-1:0] p;
    term_t r;
    p = $signed(ProdW'(coef)) * $signed(ProdW'({1'b0, d}));
    r.hi = p[ProdW-1:8];
    r.frac = |p[7:0];
    return r;
  endfunction

  // acc = trunc((256*acc + x) / 256): floor sum, plus one when negative and
  // the dropped fraction is nonzero
  function automatic acc_t acc_step(acc_t acc, term_t term);
    acc_t t;
    t = acc + {{(AccW-HiW){term.hi[HiW-1]}}, term.hi};
    if (t[AccW-1] && term.frac) begin
      t = t + acc_t'(1);
    end
    return t;
  endfunction

  // 200 - 200*peak/8192, truncated toward zero
  function automatic base_t cruise(sample_t peak);
    logic [PeakProdW-1:0] p;
    logic [PeakProdW-1:0] q;
    base_t r;
    p = PeakProdW'(peak) * PeakProdW'(BaseSpeed);
    q = p >> PeakShift;
    r = base_t'(BaseSpeed) - base_t'(q);
    if ((32'(p) <= 32'(BaseSpeed << PeakShift)) && (p[PeakShift-1:0] != '0)) begin
      r = r - base_t'(1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/poad_wheel.sv -----
// ----------------------------------------------------------------------------
// poad_wheel
// Braitenberg sum, divide by 350, offset, base speed and clamp for one wheel.
// ----------------------------------------------------------------------------
module poad_wheel (
  input  logic                clk,
  input  poad_pkg::stage_en_t en,
  input  poad_pkg::term_t     term [poad_pkg::NumSens],
  input  poad_pkg::base_t     base,
  input  poad_pkg::base_t     ofs,
  output poad_pkg::speed_t    speed
);
  import poad_pkg::*;

  acc_t                   acc3;
  term_t                  term3 [HalfSens];
  base_t                  base3;
  acc_t                   acc4;
  base_t                  base4;
  logic                   neg5;
  logic [MulW-1:0]        prod5;
  base_t                  base5;

  acc_t                   acc3_next;
  acc_t                   acc4_next;
  logic                   neg;
  acc_t                   acc_abs;
  logic [MagW-1:0]        mag;
  logic [QuoW-1:0]        quo;
  logic signed [SumW-1:0] quo_s;
  logic signed [SumW-1:0] sum;
  speed_t                 speed_next;

  // First half of the accumulation
  always_comb begin
    acc3_next = '0;
    for (int i = 0; i < HalfSens; i++) begin
      acc3_next = acc_step(acc3_next, term[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      acc3 <= acc3_next;
      base3 <= base;
      for (int i = 0; i < HalfSens; i++) begin
        term3[i] <= term[HalfSens + i];
      end
    end
  end

  // Second half
  always_comb begin
    acc4_next = acc3;
    for (int i = 0; i < HalfSens; i++) begin
      acc4_next = acc_step(acc4_next, term3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      acc4 <= acc4_next;
      base4 <= base3;
    end
  end

  // Divide the magnitude by 350 through the reciprocal
  always_comb begin
    neg = acc4[AccW-1];
    acc_abs = neg ? -acc4 : acc4;
    mag = acc_abs[MagW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      neg5 <= neg;
      prod5 <= MulW'(mag) * MulW'(Recip);
      base5 <= base4;
    end
  end

  always_comb begin
    quo = prod5[MulW-1:RecipShift];
    quo_s = neg5 ? -$signed(SumW'(quo)) : $signed(SumW'(quo));
    sum = quo_s + SumW'(base5) + SumW'(ofs);
    if (sum > SumW'(SpeedMax)) begin
      speed_next = speed_t'(SpeedMax);
    end else if (sum < SumW'(-SpeedMax)) begin
      speed_next = speed_t'(-SpeedMax);
    end else begin
      speed_next = sum[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.so) begin
      speed <= speed_next;
    end
  end

endmodule

// ----- rtl/proximity_obstacle_avoidance_drive_unit.sv -----
// ----------------------------------------------------------------------------
// proximity_obstacle_avoidance_drive_unit
// Turns frames of eight proximity readings into a pair of wheel commands.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one request per frame, eight 12-bit readings.
//   Master stream m_*: one result per frame, left and right speed (saturated
//   to +-800) and the avoidance mode and side left by that frame.
//   APB port: weight_0..weight_7 at byte addresses 0x00..0x1C, signed Q8.8;
//   write them only while no frame is in flight.
//   Pipeline: a frame passes five pipeline registers, input, products, two
//   accumulation halves and the reciprocal multiply, then the output
//   register, where its result is valid.
//   Throughput: one frame per cycle unless stalled. The mode and side state
//   updates as a frame leaves the input register, so each frame sees its
//   predecessor. When m_tready is low the output holds and the stages behind
//   it keep filling; s_tready drops only once every stage holds a frame.
//   Reset clears all weights, the pipeline and the state (normal mode, left).
// ----------------------------------------------------------------------------
`include "proximity_obstacle_avoidance_drive_unit_defines.svh"

module proximity_obstacle_avoidance_drive_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // prox_0 .. prox_7, 12 bits each
  input  logic [poad_pkg::InW-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // left_speed[10:0], right_speed[21:11], avoid_mode[22], avoid_side[23]
  output logic [poad_pkg::OutW-1:0]    m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [poad_pkg::AddrW-1:0]   paddr,
  input  logic [poad_pkg::DataW-1:0]   pwdata,
  output logic [poad_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import poad_pkg::*;

  weight_t   weight [NumSens];
  logic      cfg_wr;
  logic [IdxW-1:0] cfg_idx;

  logic      avoiding;
  logic      turn_side;
  logic      avoid_entry;
  logic      avoid_next;
  logic      side_next;
  sample_t   peak;

  logic      v1, v2, v3, v4, v5;
  logic      ld1, ld2, ld3, ld4, ld5, ld_o;
  stage_en_t en;

  sample_t   d1 [NumSens];
  term_t     tl_next [NumSens];
  term_t     tr_next [NumSens];
  base_t     base_l_next;
  base_t     base_r_next;

  term_t     tl2 [NumSens];
  term_t     tr2 [NumSens];
  base_t     base_l2;
  base_t     base_r2;
  logic      mode2, mode3, mode4, mode5, mode_o;
  logic      side2, side3, side4, side5, side_o;
  speed_t    spd_l;
  speed_t    spd_r;

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[IdxW+1:2];
  assign prdata  = {{(DataW-WeightW){1'b0}}, weight[cfg_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumSens; i++) begin
        weight[i] <= '0;
      end
    end else if (cfg_wr) begin
      weight[cfg_idx] <= pwdata[WeightW-1:0];
    end
  end

  // Pipeline flow: a stage loads when empty or when its frame moves on
  assign ld_o = !m_tvalid || m_tready;
  assign ld5  = !v5 || ld_o;
  assign ld4  = !v4 || ld5;
  assign ld3  = !v3 || ld4;
  assign ld2  = !v2 || ld3;
  assign ld1  = !v1 || ld2;
  assign s_tready = ld1;
  assign en = '{s3: ld3, s4: ld4, s5: ld5, so: ld_o};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ld1)  v1 <= s_tvalid;
      if (ld2)  v2 <= v1;
      if (ld3)  v3 <= v2;
      if (ld4)  v4 <= v3;
      if (ld5)  v5 <= v4;
      if (ld_o) m_tvalid <= v5;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (ld1) begin
      for (int i = 0; i < NumSens; i++) begin
        d1[i] <= s_tdata[i*SampleBits +: SampleBits];
      end
    end
  end

  // Mode, side and base speeds
  always_comb begin
    peak = '0;
    for (int i = 0; i < NumSens; i++) begin
      if (d1[i] > peak) peak = d1[i];
    end

    avoid_entry = avoiding;
    side_next = turn_side;
    for (int k = 0; k < NumPairs; k++) begin
      if (!avoid_entry && (above(d1[k], AvoidTh) || above(d1[NumSens-1-k], AvoidTh))) begin
        avoid_entry = 1'b1;
        side_next = (d1[NumSens-1-k] >= d1[k]);
      end
    end

    if (!avoid_entry) begin
      base_l_next = cruise(peak);
      base_r_next = base_l_next;
    end else if (side_next) begin
      base_l_next = above(d1[NumSens-1], FollowTh) ? base_t'(MidSpeed) : base_t'(SlowSpeed);
      base_r_next = base_t'(FastSpeed);
    end else begin
      base_l_next = base_t'(FastSpeed);
      base_r_next = above(d1[0], FollowTh) ? base_t'(MidSpeed) : base_t'(SlowSpeed);
    end

    // Drop out of avoidance once everything is far; speeds above stand
    avoid_next = avoid_entry && !(int'(peak) < ExitTh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avoiding <= 1'b0;
      turn_side <= 1'b0;
    end else if (v1 && ld2) begin
      avoiding <= avoid_next;
      turn_side <= side_next;
    end
  end

  // Weighted readings; the left sum takes the mirrored weight plus 2.0
  always_comb begin
    for (int i = 0; i < NumSens; i++) begin
      tr_next[i] = make_term(CoefW'(weight[i]), d1[i]);
      tl_next[i] = make_term(CoefW'(weight[NumSens-1-i]) + CoefW'(MirrorAdd), d1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      for (int i = 0; i < NumSens; i++) begin
        tl2[i] <= tl_next[i];
        tr2[i] <= tr_next[i];
      end
      base_l2 <= base_l_next;
      base_r2 <= base_r_next;
      mode2 <= avoid_next;
      side2 <= side_next;
    end
  end

  // Carry mode and side alongside the wheel datapaths
  always_ff @(posedge clk) begin
    if (ld3) begin
      mode3 <= mode2;
      side3 <= side2;
    end
    if (ld4) begin
      mode4 <= mode3;
      side4 <= side3;
    end
    if (ld5) begin
      mode5 <= mode4;
      side5 <= side4;
    end
    if (ld_o) begin
      mode_o <= mode5;
      side_o <= side5;
    end
  end

  poad_wheel u_left (
    .clk   (clk),
    .en    (en),
    .term  (tl2),
    .base  (base_l2),
    .ofs   (base_t'(LeftOfs)),
    .speed (spd_l)
  );

  poad_wheel u_right (
    .clk   (clk),
    .en    (en),
    .term  (tr2),
    .base  (base_r2),
    .ofs   (base_t'(RightOfs)),
    .speed (spd_r)
  );

  assign m_tdata = OutW'({side_o, mode_o, spd_r, spd_l});

  `POAD_ASSERT_NXT(a_state_hold, !(v1 && ld2), $stable(avoiding) && $stable(turn_side))
  `POAD_ASSERT_IMP(a_stall_full, !s_tready, m_tvalid && !m_tready)
  `POAD_ASSERT_IMP(a_left_range, m_tvalid, (spd_l <= speed_t'(SpeedMax)) && (spd_l >= speed_t'(-SpeedMax)))
  `POAD_ASSERT_IMP(a_follow_base, v2 && mode2, (base_l2 >= base_t'(SlowSpeed)) && (base_r2 >= base_t'(SlowSpeed)))

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: obstacle avoidance drive unit bench
// Sends sensor frames on the slave stream in random bursts while the result
// stream stalls on its own pattern. Every result is compared, field by field,
// against fixed values or a model of Braitenberg sums and avoidance state.
// Weights are loaded over APB between phases, including the extreme values.
// ----------------------------------------------------------------------------
module tb;
  import poad_pkg::*;

  localparam int PipeDepth = 5;
  localparam int HangLimit = 2000;
  localparam int PhaseLen  = 180;
  localparam int NumPhases = 5;

  typedef logic [NumSens-1:0][SampleBits-1:0] frame_t;
  typedef logic [NumSens-1:0][WeightW-1:0]    weight_set_t;

  // Packs as m_tdata: left speed in the lowest bits
  typedef struct packed {
    logic   avoid_side;
    logic   avoid_mode;
    speed_t right_speed;
    speed_t left_speed;
  } drive_t;

  typedef enum logic {ROW_FRAME, ROW_WEIGHTS} row_kind_e;
  typedef enum logic [2:0] {FR_FAR, FR_APPROACH, FR_EDGE, FR_WALL, FR_ANY} frame_kind_e;
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BLOCK} rx_mode_e;

  typedef struct {
    row_kind_e kind;
    frame_t    prox;
    weight_t   wval;
    bit        typed;
    drive_t    want;
  } row_t;

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // prox_0 .. prox_7, 12 bits each
  logic [InW-1:0]       s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // left_speed[10:0], right_speed[21:11], avoid_mode[22], avoid_side[23]
  logic [OutW-1:0]      m_tdata;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [AddrW-1:0]     paddr    = '0;
  logic [DataW-1:0]     pwdata   = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  // Model state
  weight_t wt [NumSens];
  bit      in_avoid;
  bit      side_right;

  drive_t  drive_q [$];
  row_t    rows [$];
  int      mismatches;
  int      burst_left;
  int      quiet_cycles;
  int      rx_cnt;
  rx_mode_e rx_mode;

  proximity_obstacle_avoidance_drive_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic longint limit_speed(longint v);
    if (v > SpeedMax) return SpeedMax;
    if (v < -SpeedMax) return -SpeedMax;
    return v;
  endfunction

  // Wheel commands for one frame; advances the mode and side state
  function automatic drive_t predict_drive(frame_t f);
    longint d [NumSens];
    longint accl, accr, peak, ml, mr, p;
    int     i;
    bit     entered;
    drive_t r;
    accl = 0;
    accr = 0;
    peak = 0;
    entered = 1'b0;
    for (i = 0; i < NumSens; i++) begin
      d[i] = longint'(f[i]);
      if (d[i] > peak) peak = d[i];
      // truncate toward zero after every term
      accr = (accr * 256 + longint'(wt[i]) * d[i]) / 256;
      accl = (accl * 256 + (longint'(wt[NumSens-1-i]) + MirrorAdd) * d[i]) / 256;
    end
    if (!in_avoid) begin
      for (i = 0; i < NumPairs; i++) begin
        if (!entered && (d[i] > AvoidTh || d[NumSens-1-i] > AvoidTh)) begin
          entered = 1'b1;
          in_avoid = 1'b1;
          side_right = !(d[NumSens-1-i] < d[i]);
        end
      end
    end
    if (!in_avoid) begin
      p = BaseSpeed * peak;
      ml = BaseSpeed - p / (1 << PeakShift);
      if (p <= BaseSpeed * (1 << PeakShift) && p % (1 << PeakShift) != 0) ml = ml - 1;
      mr = ml;
    end else if (side_right) begin
      ml = (d[NumSens-1] > FollowTh) ? MidSpeed : SlowSpeed;
      mr = FastSpeed;
    end else begin
      ml = FastSpeed;
      mr = (d[0] > FollowTh) ? MidSpeed : SlowSpeed;
    end
    // leave avoidance only after this frame's speeds are set
    if (in_avoid && peak < ExitTh) in_avoid = 1'b0;
    r.left_speed  = speed_t'(limit_speed(ml + accl / BraitDiv + LeftOfs));
    r.right_speed = speed_t'(limit_speed(mr + accr / BraitDiv + RightOfs));
    r.avoid_mode  = in_avoid;
    r.avoid_side  = side_right;
    return r;
  endfunction

  function automatic frame_t spot(int idx, int v);
    frame_t f;
    f = '0;
    f[idx] = sample_t'(v);
    return f;
  endfunction

  function automatic frame_t flat(int v);
    frame_t f;
    int     i;
    for (i = 0; i < NumSens; i++) f[i] = sample_t'(v);
    return f;
  endfunction

  function automatic drive_t wheels(int l, int r, bit mode, bit side);
    drive_t w;
    w.left_speed  = speed_t'(l);
    w.right_speed = speed_t'(r);
    w.avoid_mode  = mode;
    w.avoid_side  = side;
    return w;
  endfunction

  function automatic void add_row(row_kind_e kind, frame_t f, weight_t v, bit typed,
                                  drive_t want);
    row_t r;
    r.kind  = kind;
    r.prox  = f;
    r.wval  = v;
    r.typed = typed;
    r.want  = want;
    rows.push_back(r);
  endfunction

  function automatic frame_t make_frame(frame_kind_e kind);
    frame_t f;
    int     i, k;
    for (i = 0; i < NumSens; i++) begin
      case (kind)
        FR_FAR:      f[i] = sample_t'($urandom_range(0, ExitTh - 1));
        FR_APPROACH: f[i] = sample_t'($urandom_range(0, AvoidTh));
        FR_WALL:     f[i] = sample_t'($urandom_range(0, AvoidTh));
        FR_ANY:      f[i] = sample_t'($urandom);
        default: begin
          case ($urandom_range(0, 13))
            0:       f[i] = '0;
            1:       f[i] = '1;
            2:       f[i] = sample_t'(ExitTh - 2);
            3:       f[i] = sample_t'(ExitTh - 1);
            4:       f[i] = sample_t'(ExitTh);
            5:       f[i] = sample_t'(ExitTh + 1);
            6:       f[i] = sample_t'(FollowTh - 1);
            7:       f[i] = sample_t'(FollowTh);
            8:       f[i] = sample_t'(FollowTh + 1);
            9:       f[i] = sample_t'(FollowTh + 2);
            10:      f[i] = sample_t'(AvoidTh - 1);
            11:      f[i] = sample_t'(AvoidTh);
            12:      f[i] = sample_t'(AvoidTh + 1);
            default: f[i] = sample_t'(AvoidTh + 2);
          endcase
        end
      endcase
    end
    if (kind == FR_APPROACH) begin
      k = $urandom_range(0, NumPairs - 1);
      if ($urandom_range(0, 1)) k = NumSens - 1 - k;
      f[k] = sample_t'($urandom_range(AvoidTh + 1, (1 << SampleBits) - 1));
      // sometimes a tie or a second high reading on the partner sensor
      case ($urandom_range(0, 3))
        0: f[NumSens-1-k] = f[k];
        1: f[NumSens-1-k] = sample_t'($urandom_range(AvoidTh + 1, (1 << SampleBits) - 1));
        default: ;
      endcase
    end
    if (kind == FR_WALL) begin
      f[0] = sample_t'($urandom_range(FollowTh - 100, FollowTh + 100));
      f[NumSens-1] = sample_t'($urandom_range(FollowTh - 100, FollowTh + 100));
    end
    return f;
  endfunction

  function automatic weight_t pick_weight();
    case ($urandom_range(0, 9))
      0:       return weight_t'(-32768);
      1:       return weight_t'(32767);
      2, 3:    return weight_t'($urandom);
      default: return weight_t'(int'($urandom_range(0, 1200)) - 600);
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < 40) begin
      $display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic send_frame(frame_t f, bit typed, drive_t want);
    drive_t model;
    s_tvalid <= 1'b1;
    s_tdata  <= InW'(f);
    do @(posedge clk); while (!s_tready);
    model = predict_drive(f);
    drive_q.push_back(typed ? want : model);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Hold off until the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic load_weights(weight_set_t w);
    int i;
    for (i = 0; i < NumSens; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= AddrW'(i * 4);
      pwdata  <= {{(DataW - WeightW){w[i][WeightW-1]}}, w[i]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      wt[i] = weight_t'(w[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: stall pattern, checking and watchdog
  always @(posedge clk) begin : result_side
    drive_t got;
    drive_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_cnt   <= 0;
      rx_mode  <= RX_FREE;
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = drive_t'(m_tdata);
        if (drive_q.size() == 0) begin
          report_mismatch("result with nothing pending, left_speed",
                          longint'(got.left_speed), 0);
        end else begin
          want = drive_q.pop_front();
          if (got.left_speed != want.left_speed)
            report_mismatch("left_speed", longint'(got.left_speed),
                            longint'(want.left_speed));
          if (got.right_speed != want.right_speed)
            report_mismatch("right_speed", longint'(got.right_speed),
                            longint'(want.right_speed));
          if (got.avoid_mode != want.avoid_mode)
            report_mismatch("avoid_mode", got.avoid_mode, want.avoid_mode);
          if (got.avoid_side != want.avoid_side)
            report_mismatch("avoid_side", got.avoid_side, want.avoid_side);
        end
      end
      rx_cnt <= (rx_cnt + 1) % 64;
      if (rx_cnt == 63) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_FREE:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= (rx_cnt % 4 == 0);
        default:   m_tready <= (rx_cnt >= 24);
      endcase
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= HangLimit) begin
        $display("proximity_obstacle_avoidance_drive_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          n, phase, sent;
    weight_set_t ws;
    for (n = 0; n < NumSens; n++) wt[n] = '0;
    in_avoid   = 1'b0;
    side_right = 1'b0;
    mismatches = 0;
    burst_left = 0;

    // Weights are zero after reset, so the left sum is twice the readings
    add_row(ROW_FRAME, flat(0), '0, 1'b1, wheels(266, 272, 1'b0, 1'b0));
    add_row(ROW_FRAME, flat(4095), '0, 1'b1, wheels(393, 222, 1'b1, 1'b1));
    add_row(ROW_FRAME, flat(0), '0, 1'b1, wheels(166, 222, 1'b0, 1'b1));
    add_row(ROW_FRAME, spot(0, 4095), '0, 1'b1, wheels(239, 212, 1'b1, 1'b0));
    add_row(ROW_FRAME, flat(0), '0, 1'b1, wheels(216, 172, 1'b0, 1'b0));
    add_row(ROW_FRAME, spot(1, 2101), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(69), '0, 1'b0, '0);
    add_row(ROW_FRAME, spot(6, 2101), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(70), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(69), '0, 1'b0, '0);
    add_row(ROW_FRAME, spot(2, 2101) | spot(5, 2101), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(0), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(2100), '0, 1'b0, '0);
    add_row(ROW_FRAME, spot(5, 2101) | spot(2, 2000), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(0), '0, 1'b0, '0);
    add_row(ROW_FRAME, spot(0, 3000) | spot(7, 1301), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(0), '0, 1'b0, '0);
    add_row(ROW_FRAME, spot(6, 3000) | spot(7, 1300), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(0), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(12'hAAA), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(12'h555), '0, 1'b0, '0);
    add_row(ROW_WEIGHTS, '0, weight_t'(-32768), 1'b0, '0);
    add_row(ROW_FRAME, flat(4095), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(12'hAAA), '0, 1'b0, '0);
    add_row(ROW_WEIGHTS, '0, weight_t'(32767), 1'b0, '0);
    add_row(ROW_FRAME, flat(4095), '0, 1'b0, '0);
    add_row(ROW_FRAME, flat(0), '0, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[n]) begin
      if (rows[n].kind == ROW_WEIGHTS) begin
        settle();
        load_weights({NumSens{rows[n].wval}});
      end else begin
        send_frame(rows[n].prox, rows[n].typed, rows[n].want);
      end
    end

    // Random phases: approach, a few frames near the obstacle, then clear
    for (phase = 0; phase < NumPhases; phase++) begin
      settle();
      for (n = 0; n < NumSens; n++) ws[n] = pick_weight();
      load_weights(ws);
      sent = 0;
      while (sent < PhaseLen) begin
        if ($urandom_range(0, 7) != 0) begin
          send_frame(make_frame(FR_APPROACH), 1'b0, '0);
          sent++;
        end
        repeat ($urandom_range(0, 6)) begin
          send_frame(make_frame(frame_kind_e'($urandom_range(FR_FAR, FR_ANY))), 1'b0, '0);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          send_frame(make_frame(FR_FAR), 1'b0, '0);
          sent++;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (2 * PipeDepth) @(posedge clk);
    if (mismatches == 0) begin
      $display("proximity_obstacle_avoidance_drive_unit: match");
    end else begin
      $display("proximity_obstacle_avoidance_drive_unit: mismatch");
    end
    $finish;
  end

endmodule
